/* rtl/pfsa_pkg.sv */
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared constants, codes and control structs of the page frame allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  localparam int unsigned PAGES_PER_RANGE = 1024;
  localparam int unsigned NUM_RANGES      = 2;
  localparam int unsigned FLAG_BITS       = 8;

  localparam int unsigned IDX_W      = $clog2(PAGES_PER_RANGE);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned RANGE_W    = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int unsigned MEM_AW     = RANGE_W + IDX_W;
  localparam int unsigned MEM_DEPTH  = NUM_RANGES * PAGES_PER_RANGE;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int unsigned PAGES_W    = 11;
  localparam int unsigned INUSE_W    = 2;
  localparam int unsigned REQ_W      = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned CFG_AW     = 5;

  localparam logic [FLAG_BITS-1:0] FLG_USED = FLAG_BITS'(1);
  localparam logic [FLAG_BITS-1:0] FLG_HEAD = FLAG_BITS'(2);

  typedef enum logic [2:0] {
    REG_RANGES_IN_USE = 3'd0,
    REG_RANGE_BASE_0  = 3'd1,
    REG_RANGE_PAGES_0 = 3'd2,
    REG_RANGE_BASE_1  = 3'd3,
    REG_RANGE_PAGES_1 = 3'd4
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGE  = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [INUSE_W-1:0]                    in_use;
    logic [NUM_RANGES-1:0][PFN_W-1:0]      base;
    logic [NUM_RANGES-1:0][PAGES_W-1:0]    pages;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] range;
    logic [PAGES_W-1:0] pages;
  } init_t;

  typedef struct packed {
    logic              busy;
    logic              we;
    logic [MEM_AW-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic    take;
    logic    alloc_pop;
    logic    alloc_fin;
    logic    chk_rd;
    logic    next_r;
    logic    walk_push;
    logic    status_we;
    status_e status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic pfn_zero;
    logic any_free;
    logic own;
    logic more_r;
    logic head_ok;
    logic full;
    logic last_page;
    logic tail_ok;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/pfsa_ram.sv */
// ----------------------------------------------------------------------------
// pfsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pfsa_regs.sv */
// ----------------------------------------------------------------------------
// pfsa_regs
// APB register file and range clearing sequencer.
// ----------------------------------------------------------------------------
module pfsa_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [pfsa_pkg::CFG_AW-1:0]   paddr_i,
  input  logic [pfsa_pkg::CFG_DW-1:0]   pwdata_i,
  output logic [pfsa_pkg::CFG_DW-1:0]   prdata_o,
  output logic                          pready_o,
  output pfsa_pkg::cfg_t                cfg_o,
  output pfsa_pkg::init_t               init_o,
  output pfsa_pkg::clr_t                clr_o
);

  pfsa_pkg::reg_idx_e                     reg_idx;
  logic                                   wr;
  logic                                   wr_pages;
  logic [pfsa_pkg::RANGE_W-1:0]           wr_r;
  logic [pfsa_pkg::PAGES_W-1:0]           pages_sat;
  logic [pfsa_pkg::INUSE_W-1:0]           in_use_sat;

  logic [pfsa_pkg::INUSE_W-1:0]           in_use_q;
  logic [1:0][pfsa_pkg::PFN_W-1:0]        base_q;
  logic [1:0][pfsa_pkg::PAGES_W-1:0]      pages_q;

  logic [pfsa_pkg::NUM_RANGES-1:0]        pend_q, pend_d;
  logic                                   act_q, act_d;
  logic [pfsa_pkg::RANGE_W-1:0]           act_r_q, act_r_d;
  logic [pfsa_pkg::IDX_W-1:0]             cnt_q, cnt_d;

  assign reg_idx  = pfsa_pkg::reg_idx_e'(paddr_i[pfsa_pkg::CFG_AW-1:2]);
  assign wr       = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  assign pages_sat = (pwdata_i[pfsa_pkg::PAGES_W-1:0] >
                      pfsa_pkg::PAGES_W'(pfsa_pkg::PAGES_PER_RANGE)) ?
                     pfsa_pkg::PAGES_W'(pfsa_pkg::PAGES_PER_RANGE) :
                     pwdata_i[pfsa_pkg::PAGES_W-1:0];
  assign in_use_sat = (pwdata_i[pfsa_pkg::INUSE_W-1:0] >
                       pfsa_pkg::INUSE_W'(pfsa_pkg::NUM_RANGES)) ?
                      pfsa_pkg::INUSE_W'(pfsa_pkg::NUM_RANGES) :
                      pwdata_i[pfsa_pkg::INUSE_W-1:0];

  always_comb begin
    wr_pages = 1'b0;
    wr_r     = '0;
    unique case (reg_idx)
      pfsa_pkg::REG_RANGE_PAGES_0: begin
        wr_pages = wr;
        wr_r     = pfsa_pkg::RANGE_W'(0);
      end
      pfsa_pkg::REG_RANGE_PAGES_1: begin
        wr_pages = wr;
        wr_r     = pfsa_pkg::RANGE_W'(1);
      end
      default: begin
        wr_pages = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      base_q   <= '0;
      pages_q  <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        pfsa_pkg::REG_RANGES_IN_USE: in_use_q  <= in_use_sat;
        pfsa_pkg::REG_RANGE_BASE_0:  base_q[0] <= pwdata_i[pfsa_pkg::PFN_W-1:0];
        pfsa_pkg::REG_RANGE_PAGES_0: pages_q[0] <= pages_sat;
        pfsa_pkg::REG_RANGE_BASE_1:  base_q[1] <= pwdata_i[pfsa_pkg::PFN_W-1:0];
        pfsa_pkg::REG_RANGE_PAGES_1: pages_q[1] <= pages_sat;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (reg_idx)
      pfsa_pkg::REG_RANGES_IN_USE: prdata_o = pfsa_pkg::CFG_DW'(in_use_q);
      pfsa_pkg::REG_RANGE_BASE_0:  prdata_o = pfsa_pkg::CFG_DW'(base_q[0]);
      pfsa_pkg::REG_RANGE_PAGES_0: prdata_o = pfsa_pkg::CFG_DW'(pages_q[0]);
      pfsa_pkg::REG_RANGE_BASE_1:  prdata_o = pfsa_pkg::CFG_DW'(base_q[1]);
      pfsa_pkg::REG_RANGE_PAGES_1: prdata_o = pfsa_pkg::CFG_DW'(pages_q[1]);
      default:                     prdata_o = '0;
    endcase
  end

  // Sweep one range at a time: identity stack, cleared flags.
  always_comb begin
    pend_d  = pend_q;
    act_d   = act_q;
    act_r_d = act_r_q;
    cnt_d   = cnt_q;
    if (act_q) begin
      cnt_d = cnt_q + pfsa_pkg::IDX_W'(1);
      if (cnt_q == '1) begin
        act_d = 1'b0;
      end
    end else if (pend_q != '0) begin
      for (int i = pfsa_pkg::NUM_RANGES - 1; i >= 0; i--) begin
        if (pend_q[i]) begin
          act_r_d = pfsa_pkg::RANGE_W'(i);
        end
      end
      act_d           = 1'b1;
      cnt_d           = '0;
      pend_d[act_r_d] = 1'b0;
    end
    if (wr_pages && !(act_d && (act_r_d == wr_r))) begin
      pend_d[wr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '1;
      act_q   <= 1'b0;
      act_r_q <= '0;
      cnt_q   <= '0;
    end else begin
      pend_q  <= pend_d;
      act_q   <= act_d;
      act_r_q <= act_r_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    cfg_o.in_use = in_use_q;
    for (int i = 0; i < pfsa_pkg::NUM_RANGES; i++) begin
      cfg_o.base[i]  = base_q[i];
      cfg_o.pages[i] = pages_q[i];
    end
  end

  assign init_o.valid = wr_pages;
  assign init_o.range = wr_r;
  assign init_o.pages = pages_sat;

  assign clr_o.busy = act_q | (|pend_q) | wr_pages;
  assign clr_o.we   = act_q;
  assign clr_o.addr = {act_r_q, cnt_q};

endmodule

/* rtl/pfsa_ctrl.sv */
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Sequencer for allocate and free requests.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  pfsa_pkg::op_e    s_op_i,
  input  logic             clr_busy_i,
  input  pfsa_pkg::sts_t   sts_i,
  output pfsa_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_ALLOC_WR,
    S_FREE_CHK,
    S_FREE_FLG,
    S_WALK,
    S_WALK_FLG,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE) && !clr_busy_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i && s_tready_o) begin
          cmd_o.take = 1'b1;
          state_d    = (s_op_i == pfsa_pkg::OP_ALLOC) ? S_ALLOC : S_FREE_CHK;
        end
      end
      S_ALLOC: begin
        if (sts_i.any_free) begin
          cmd_o.alloc_pop = 1'b1;
          state_d         = S_ALLOC_WR;
        end else begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = pfsa_pkg::ST_NO_PAGE;
          state_d         = S_DONE;
        end
      end
      S_ALLOC_WR: begin
        cmd_o.alloc_fin = 1'b1;
        cmd_o.status_we = 1'b1;
        cmd_o.status    = pfsa_pkg::ST_OK;
        state_d         = S_DONE;
      end
      S_FREE_CHK: begin
        priority if (sts_i.pfn_zero) begin
          state_d = S_DONE;
        end else if (sts_i.own) begin
          cmd_o.chk_rd = 1'b1;
          state_d      = S_FREE_FLG;
        end else if (sts_i.more_r) begin
          cmd_o.next_r = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FREE_FLG: begin
        priority if (sts_i.head_ok) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = pfsa_pkg::ST_OK;
          state_d         = S_WALK;
        end else if (sts_i.more_r) begin
          cmd_o.next_r = 1'b1;
          state_d      = S_FREE_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        if (sts_i.full) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = pfsa_pkg::ST_OVERFLOW;
          state_d         = S_DONE;
        end else begin
          cmd_o.walk_push = 1'b1;
          state_d         = sts_i.last_page ? S_DONE : S_WALK_FLG;
        end
      end
      S_WALK_FLG: begin
        state_d = sts_i.tail_ok ? S_WALK : S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/pfsa_datapath.sv */
// ----------------------------------------------------------------------------
// pfsa_datapath
// Stack tops, free stack and page flag memories, request and result registers.
// ----------------------------------------------------------------------------
module pfsa_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfsa_pkg::cfg_t                   cfg_i,
  input  pfsa_pkg::init_t                  init_i,
  input  pfsa_pkg::clr_t                   clr_i,
  input  pfsa_pkg::cmd_t                   cmd_i,
  output pfsa_pkg::sts_t                   sts_o,
  input  logic [pfsa_pkg::REQ_W-1:0]       s_req_i,
  input  logic [pfsa_pkg::ADDR_W-1:0]      s_addr_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [pfsa_pkg::ADDR_W-1:0]      m_addr_o,
  output logic [pfsa_pkg::PAGES_W-1:0]     m_freed_o,
  output pfsa_pkg::status_e                m_status_o
);

  localparam int unsigned RC_W = pfsa_pkg::INUSE_W + 1;
  localparam logic [pfsa_pkg::FLAG_BITS-1:0] FLG_UH = pfsa_pkg::FLG_USED | pfsa_pkg::FLG_HEAD;

  logic [pfsa_pkg::CNT_W-1:0]     top_q [pfsa_pkg::NUM_RANGES];
  logic [pfsa_pkg::CNT_W-1:0]     top_d [pfsa_pkg::NUM_RANGES];

  logic [pfsa_pkg::REQ_W-1:0]     req_q;
  logic [pfsa_pkg::PFN_W-1:0]     pfn_q;
  logic [pfsa_pkg::RANGE_W-1:0]   r_q;
  logic [pfsa_pkg::CNT_W-1:0]     idx_q;
  logic [pfsa_pkg::PAGES_W-1:0]   freed_q;
  pfsa_pkg::status_e              status_q;
  logic [pfsa_pkg::ADDR_W-1:0]    addr_q;

  logic                           out_vld_q;
  logic [pfsa_pkg::ADDR_W-1:0]    out_addr_q;
  logic [pfsa_pkg::PAGES_W-1:0]   out_freed_q;
  pfsa_pkg::status_e              out_status_q;

  logic                           any_free;
  logic [pfsa_pkg::RANGE_W-1:0]   pick_r;
  logic [pfsa_pkg::CNT_W-1:0]     top_dec;
  logic [pfsa_pkg::CNT_W-1:0]     cur_top;
  logic [pfsa_pkg::PAGES_W-1:0]   cur_pages;
  logic [pfsa_pkg::PFN_W-1:0]     cur_base;
  logic [pfsa_pkg::PFN_W-1:0]     rel;
  logic [pfsa_pkg::CNT_W-1:0]     idx_nx;
  logic [pfsa_pkg::PFN_W-1:0]     page_pfn;

  logic                           stk_we, stk_re;
  logic [pfsa_pkg::MEM_AW-1:0]    stk_waddr, stk_raddr;
  logic [pfsa_pkg::IDX_W-1:0]     stk_wdata, stk_rdata;
  logic                           fl_we, fl_re;
  logic [pfsa_pkg::MEM_AW-1:0]    fl_waddr, fl_raddr;
  logic [pfsa_pkg::FLAG_BITS-1:0] fl_wdata, fl_rdata;

  always_comb begin
    any_free = 1'b0;
    pick_r   = '0;
    for (int i = pfsa_pkg::NUM_RANGES - 1; i >= 0; i--) begin
      if ((RC_W'(i) < RC_W'(cfg_i.in_use)) && (top_q[i] != '0)) begin
        any_free = 1'b1;
        pick_r   = pfsa_pkg::RANGE_W'(i);
      end
    end
  end

  assign top_dec   = top_q[pick_r] - pfsa_pkg::CNT_W'(1);
  assign cur_top   = top_q[r_q];
  assign cur_pages = cfg_i.pages[r_q];
  assign cur_base  = cfg_i.base[r_q];
  assign rel       = pfn_q - cur_base;
  assign idx_nx    = idx_q + pfsa_pkg::CNT_W'(1);
  assign page_pfn  = cur_base + pfsa_pkg::PFN_W'(stk_rdata);

  assign sts_o.pfn_zero  = (pfn_q == '0);
  assign sts_o.any_free  = any_free;
  assign sts_o.own       = (pfn_q >= cur_base) && (rel < pfsa_pkg::PFN_W'(cur_pages)) &&
                           (RC_W'(r_q) < RC_W'(cfg_i.in_use));
  assign sts_o.more_r    = (r_q != pfsa_pkg::RANGE_W'(pfsa_pkg::NUM_RANGES - 1)) &&
                           ((RC_W'(r_q) + RC_W'(1)) < RC_W'(cfg_i.in_use));
  assign sts_o.head_ok   = ((fl_rdata & FLG_UH) == FLG_UH);
  assign sts_o.tail_ok   = ((fl_rdata & FLG_UH) == pfsa_pkg::FLG_USED);
  assign sts_o.full      = (cur_top >= cur_pages);
  assign sts_o.last_page = (idx_nx >= cur_pages);
  assign sts_o.out_busy  = out_vld_q && !m_tready_i;

  assign stk_we    = clr_i.we | cmd_i.walk_push;
  assign stk_waddr = clr_i.we ? clr_i.addr : {r_q, cur_top[pfsa_pkg::IDX_W-1:0]};
  assign stk_wdata = clr_i.we ? clr_i.addr[pfsa_pkg::IDX_W-1:0] : idx_q[pfsa_pkg::IDX_W-1:0];
  assign stk_re    = cmd_i.alloc_pop;
  assign stk_raddr = {pick_r, top_dec[pfsa_pkg::IDX_W-1:0]};

  always_comb begin
    fl_we    = clr_i.we | cmd_i.alloc_fin | cmd_i.walk_push;
    fl_waddr = {r_q, idx_q[pfsa_pkg::IDX_W-1:0]};
    fl_wdata = '0;
    priority if (clr_i.we) begin
      fl_waddr = clr_i.addr;
    end else if (cmd_i.alloc_fin) begin
      fl_waddr = {r_q, stk_rdata};
      fl_wdata = pfsa_pkg::FLAG_BITS'(req_q) | FLG_UH;
    end else begin
      fl_waddr = {r_q, idx_q[pfsa_pkg::IDX_W-1:0]};
    end
  end

  assign fl_re    = cmd_i.chk_rd | cmd_i.walk_push;
  assign fl_raddr = cmd_i.chk_rd ? {r_q, rel[pfsa_pkg::IDX_W-1:0]} :
                                   {r_q, idx_nx[pfsa_pkg::IDX_W-1:0]};

  pfsa_ram #(
    .WIDTH(pfsa_pkg::IDX_W),
    .DEPTH(pfsa_pkg::MEM_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  pfsa_ram #(
    .WIDTH(pfsa_pkg::FLAG_BITS),
    .DEPTH(pfsa_pkg::MEM_DEPTH)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .re_i    (fl_re),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  always_comb begin
    for (int i = 0; i < pfsa_pkg::NUM_RANGES; i++) begin
      top_d[i] = top_q[i];
    end
    if (init_i.valid) begin
      top_d[init_i.range] = init_i.pages;
    end
    if (cmd_i.alloc_pop) begin
      top_d[pick_r] = top_dec;
    end
    if (cmd_i.walk_push) begin
      top_d[r_q] = cur_top + pfsa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pfsa_pkg::NUM_RANGES; i++) begin
        top_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < pfsa_pkg::NUM_RANGES; i++) begin
        top_q[i] <= top_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (cmd_i.take) begin
      r_q <= '0;
    end else if (cmd_i.alloc_pop) begin
      r_q <= pick_r;
    end else if (cmd_i.next_r) begin
      r_q <= r_q + pfsa_pkg::RANGE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q   <= s_req_i;
      pfn_q   <= s_addr_i[pfsa_pkg::ADDR_W-1:pfsa_pkg::PAGE_SHIFT];
      idx_q   <= '0;
      freed_q <= '0;
      addr_q  <= '0;
    end else begin
      if (cmd_i.alloc_fin) begin
        addr_q <= {page_pfn, {pfsa_pkg::PAGE_SHIFT{1'b0}}};
      end
      if (cmd_i.chk_rd) begin
        idx_q <= pfsa_pkg::CNT_W'(rel);
      end
      if (cmd_i.walk_push) begin
        idx_q   <= idx_nx;
        freed_q <= freed_q + pfsa_pkg::PAGES_W'(1);
      end
    end
    if (cmd_i.take) begin
      status_q <= pfsa_pkg::ST_IGNORED;
    end else if (cmd_i.status_we) begin
      status_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_addr_q   <= addr_q;
      out_freed_q  <= freed_q;
      out_status_q <= status_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_addr_o   = out_addr_q;
  assign m_freed_o  = out_freed_q;
  assign m_status_o = out_status_q;

endmodule

/* rtl/page_frame_stack_allocator_core.sv */
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_core
// Free-stack allocator of 4 KiB page frames over two configured ranges.
// ----------------------------------------------------------------------------
// An allocate pops the free stack memory, then writes the page flags, then
// loads the output register. A free checks the bounds of each range in turn;
// on a range that holds the page it reads the flag memory, then for each page
// returned pushes it and reads the flags of the next page, stopping at the
// page that ends the range, on a full stack or at a page not flagged as a used
// tail, and then loads the result. After reset, and after each write of a range
// page count, the block sweeps the stack and flag memories of that range (of
// every range after reset), and accepts no beat until the sweep ends.
// A result beat waits in an output register while the next request is taken.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] request_flags, [39:8] target_address
  input  logic [39:0]                    s_axis_tdata,
  // [0] operation
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] result_address, [42:32] freed_pages, [44:43] status
  output logic [47:0]                    m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfsa_pkg::CFG_AW-1:0]    paddr,
  input  logic [pfsa_pkg::CFG_DW-1:0]    pwdata,
  output logic [pfsa_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);

  pfsa_pkg::cfg_t                    cfg;
  pfsa_pkg::init_t                   init;
  pfsa_pkg::clr_t                    clr;
  pfsa_pkg::cmd_t                    cmd;
  pfsa_pkg::sts_t                    sts;
  pfsa_pkg::op_e                     s_op;
  logic [pfsa_pkg::ADDR_W-1:0]       m_addr;
  logic [pfsa_pkg::PAGES_W-1:0]      m_freed;
  pfsa_pkg::status_e                 m_status;

  assign s_op = pfsa_pkg::op_e'(s_axis_tuser);

  pfsa_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg),
    .init_o    (init),
    .clr_o     (clr)
  );

  pfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_op_i     (s_op),
    .clr_busy_i (clr.busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfsa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .init_i     (init),
    .clr_i      (clr),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_req_i    (s_axis_tdata[7:0]),
    .s_addr_i   (s_axis_tdata[39:8]),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_addr_o   (m_addr),
    .m_freed_o  (m_freed),
    .m_status_o (m_status)
  );

  assign m_axis_tdata = {3'b000, m_status, m_freed, m_addr};

endmodule
